[sv/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tick task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SLOT_W      = 4;
  localparam int TIME_W      = 16;
  localparam int RUNS_W      = 8;
  localparam int SLOT_LIMIT  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  typedef enum logic [1:0] {
    KIND_REG  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_DISP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DISP
  } st_t;

  typedef struct packed {
    kind_t              op;
    logic [SLOT_W-1:0]  slot;
    logic               in_range;
    logic [TIME_W-1:0]  start_delay;
    logic [TIME_W-1:0]  period;
  } cmd_t;

endpackage

[sv/tts_cmd_if.sv]
// ----------------------------------------------------------------------------
// tts_cmd_if
// Request channel of the scheduler: valid/ready with the command fields.
// ----------------------------------------------------------------------------
interface tts_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [tts_pkg::SLOT_W-1:0]  slot;
  logic [tts_pkg::TIME_W-1:0]  start_delay;
  logic [tts_pkg::TIME_W-1:0]  period;

  modport source (output valid, kind, slot, start_delay, period, input ready);
  modport sink   (input valid, kind, slot, start_delay, period, output ready);
endinterface

[sv/tts_res_if.sv]
// ----------------------------------------------------------------------------
// tts_res_if
// Result channel of the scheduler: valid/ready with slot, status and last.
// ----------------------------------------------------------------------------
interface tts_res_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::SLOT_W-1:0]  slot_id;
  logic                        ok;
  logic                        last;

  modport source (output valid, slot_id, ok, last, input ready);
  modport sink   (input valid, slot_id, ok, last, output ready);
endinterface

[sv/tts_front.sv]
// ----------------------------------------------------------------------------
// tts_front
// Accepts requests, decodes the kind and range-checks the slot, and holds
// them in a short queue for the execution engine.
// ----------------------------------------------------------------------------
module tts_front #(
  parameter int ACT = 16
) (
  input  logic           clk,
  input  logic           rst,
  tts_cmd_if.sink        cmd,
  output logic           q_valid,
  output tts_pkg::cmd_t  q_cmd,
  input  logic           q_pop
);

  localparam int QD = tts_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  tts_pkg::cmd_t   q [QD];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CW-1:0]   cnt;
  logic            push;
  tts_pkg::cmd_t   dec;

  assign cmd.ready = (cnt != CW'(QD));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (cnt != '0);
  assign q_cmd     = q[rp];

  always_comb begin
    dec.op          = tts_pkg::kind_t'(cmd.kind);
    dec.slot        = cmd.slot;
    dec.in_range    = ({1'b0, cmd.slot} < 5'(ACT));
    dec.start_delay = cmd.start_delay;
    dec.period      = cmd.period;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QD - 1)) ? '0 : wp + 1'b1;
      end
      if (q_pop) begin
        rp <= (rp == PW'(QD - 1)) ? '0 : rp + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QD))
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue count missed a push");

endmodule

[sv/tts_back.sv]
// ----------------------------------------------------------------------------
// tts_back
// Execution engine: holds the slot table, walks it one slot per cycle for tick
// and dispatch (unless a result stalls), drives results via an output register.
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int ACT = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  tts_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  tts_res_if.source      res
);

  localparam int IW = (ACT > 1) ? $clog2(ACT) : 1;
  localparam int SW = tts_pkg::SLOT_W;
  localparam int TW = tts_pkg::TIME_W;
  localparam int RW = tts_pkg::RUNS_W;

  // slot table
  logic [ACT-1:0]  occ;
  logic [ACT-1:0]  rdy;
  logic [TW-1:0]   dly  [ACT];
  logic [TW-1:0]   per  [ACT];
  logic [RW-1:0]   runs [ACT];

  tts_pkg::st_t    st;
  tts_pkg::st_t    st_next;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   idx_next;

  // output register
  logic            ov;
  logic [SW-1:0]   o_id;
  logic            o_ok;
  logic            o_last;

  logic            can_emit;
  logic            adv;
  logic            at_end;
  logic [IW-1:0]   free_idx;
  logic            any_free;
  logic [ACT-1:0]  above;
  logic [IW-1:0]   del_idx;

  logic            cur_occ;
  logic [TW-1:0]   cur_dly;
  logic [TW-1:0]   cur_per;
  logic [RW-1:0]   cur_runs;
  logic [TW-1:0]   tick_dly;
  logic [RW-1:0]   tick_runs;

  logic            emit;
  logic [SW-1:0]   em_id;
  logic            em_ok;
  logic            em_last;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  logic            wr_occ;
  logic            wr_rdy;
  logic [TW-1:0]   wr_dly;
  logic [TW-1:0]   wr_per;
  logic [RW-1:0]   wr_runs;

  assign can_emit = !ov || res.ready;
  assign at_end   = (idx == IW'(ACT - 1));
  assign adv      = !rdy[idx] || can_emit;
  assign del_idx  = q_cmd.slot[IW-1:0];

  assign cur_occ  = occ[idx];
  assign cur_dly  = dly[idx];
  assign cur_per  = per[idx];
  assign cur_runs = runs[idx];

  assign res.valid   = ov;
  assign res.slot_id = o_id;
  assign res.ok      = o_ok;
  assign res.last    = o_last;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = ACT - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        free_idx = IW'(i);
      end
    end
  end
  assign any_free = ~&occ;

  always_comb begin
    for (int i = 0; i < ACT; i++) begin
      above[i] = (IW'(i) > idx);
    end
  end

  // one tick applied to the current slot
  always_comb begin
    tick_dly  = (cur_dly != '0) ? cur_dly - 1'b1 : '0;
    tick_runs = cur_runs;
    if (tick_dly == '0) begin
      if (cur_runs != tts_pkg::RUNS_MAX) begin
        tick_runs = cur_runs + 1'b1;
      end
      if (cur_per != '0) begin
        tick_dly = cur_per;
      end
    end
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      tts_pkg::ST_IDLE: begin
        if (q_valid && q_cmd.op == tts_pkg::KIND_TICK) begin
          st_next = tts_pkg::ST_TICK;
        end else if (q_valid && q_cmd.op == tts_pkg::KIND_DISP && rdy != '0) begin
          st_next = tts_pkg::ST_DISP;
        end
      end
      tts_pkg::ST_TICK: begin
        if (at_end) begin
          st_next = tts_pkg::ST_IDLE;
        end
      end
      tts_pkg::ST_DISP: begin
        if (at_end && adv) begin
          st_next = tts_pkg::ST_IDLE;
        end
      end
      default: st_next = tts_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    q_pop    = 1'b0;
    emit     = 1'b0;
    em_id    = '0;
    em_ok    = 1'b0;
    em_last  = 1'b1;
    wr_en    = 1'b0;
    wr_idx   = idx;
    wr_occ   = 1'b0;
    wr_rdy   = 1'b0;
    wr_dly   = '0;
    wr_per   = '0;
    wr_runs  = '0;
    idx_next = idx;
    unique case (st)
      tts_pkg::ST_IDLE: begin
        idx_next = '0;
        if (q_valid) begin
          unique case (q_cmd.op)
            tts_pkg::KIND_REG: begin
              if (can_emit) begin
                q_pop = 1'b1;
                emit  = 1'b1;
                if (any_free) begin
                  em_id   = SW'(free_idx);
                  em_ok   = 1'b1;
                  wr_en   = 1'b1;
                  wr_idx  = free_idx;
                  wr_occ  = 1'b1;
                  wr_dly  = q_cmd.start_delay;
                  wr_per  = q_cmd.period;
                end
              end
            end
            tts_pkg::KIND_DEL: begin
              if (can_emit) begin
                q_pop = 1'b1;
                emit  = 1'b1;
                em_id = q_cmd.slot;
                if (q_cmd.in_range && occ[del_idx]) begin
                  em_ok  = 1'b1;
                  wr_en  = 1'b1;
                  wr_idx = del_idx;
                end
              end
            end
            tts_pkg::KIND_TICK: begin
              q_pop = 1'b1;
            end
            tts_pkg::KIND_DISP: begin
              if (rdy != '0) begin
                q_pop = 1'b1;
              end else if (can_emit) begin
                // nothing ready: a single failed result
                q_pop = 1'b1;
                emit  = 1'b1;
              end
            end
            default: q_pop = 1'b0;
          endcase
        end
      end
      tts_pkg::ST_TICK: begin
        idx_next = at_end ? '0 : idx + 1'b1;
        if (cur_occ) begin
          wr_en   = 1'b1;
          wr_occ  = 1'b1;
          wr_dly  = tick_dly;
          wr_per  = cur_per;
          wr_runs = tick_runs;
          wr_rdy  = (tick_runs != '0);
        end
      end
      tts_pkg::ST_DISP: begin
        if (adv) begin
          idx_next = at_end ? '0 : idx + 1'b1;
        end
        if (rdy[idx] && can_emit) begin
          emit    = 1'b1;
          em_id   = SW'(idx);
          em_ok   = 1'b1;
          em_last = ~|(rdy & above);
          wr_en   = 1'b1;
          // one-shot task leaves the table once it runs
          if (cur_per != '0) begin
            wr_occ  = 1'b1;
            wr_dly  = cur_dly;
            wr_per  = cur_per;
            wr_runs = cur_runs - 1'b1;
            wr_rdy  = (cur_runs != RW'(1));
          end
        end
      end
      default: idx_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= tts_pkg::ST_IDLE;
      idx <= '0;
      occ <= '0;
      rdy <= '0;
      ov  <= 1'b0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
      if (wr_en) begin
        occ[wr_idx] <= wr_occ;
        rdy[wr_idx] <= wr_rdy;
      end
      if (emit) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dly[wr_idx]  <= wr_dly;
      per[wr_idx]  <= wr_per;
      runs[wr_idx] <= wr_runs;
    end
    if (emit) begin
      o_id   <= em_id;
      o_ok   <= em_ok;
      o_last <= em_last;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!ov || res.ready))
    else $error("result written over an untaken result");

  a_rdy_occ: assert property (@(posedge clk) disable iff (rst)
    (rdy & ~occ) == '0)
    else $error("ready slot that is not occupied");

  a_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (st == tts_pkg::ST_TICK) |-> (!emit && !q_pop))
    else $error("tick walk produced a result or popped a request");

  a_disp_slot: assert property (@(posedge clk) disable iff (rst)
    (emit && st == tts_pkg::ST_DISP) |-> (occ[idx] && runs[idx] != '0))
    else $error("dispatched a slot with no pending run");

endmodule

[sv/tick_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// tick_task_scheduler_top
// Table of periodic and one-shot tasks driven by register, delete, tick
// and dispatch requests.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   kind, slot, start_delay, period
//   res      out  valid/ready   slot_id, ok, last
//
// Register and delete are done directly from idle; tick and dispatch walk
// the min(SLOTS,16) table slots one slot per cycle (dispatch with nothing
// ready gives a single failed result). A two-entry request queue and a
// result register decouple both sides. Reset clears the table.
// A stalled result holds the dispatch walk on the ready slot.
// ----------------------------------------------------------------------------
module tick_task_scheduler_top #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  tts_cmd_if.sink     cmd,
  tts_res_if.source   res
);

  localparam int ACT = (SLOTS > tts_pkg::SLOT_LIMIT) ? tts_pkg::SLOT_LIMIT : SLOTS;

  logic           q_valid;
  logic           q_pop;
  tts_pkg::cmd_t  q_cmd;

  tts_front #(.ACT(ACT)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  tts_back #(.ACT(ACT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tick_task_scheduler_top. A table model inside the
// bench predicts the replies of each request (ticks give none), and every reply
// is compared with the oldest prediction. The stimulus runs in this order:
//   - directed requests on an empty and a full table
//   - run-count saturation
//   - random request streams
//   - a long result stall that backs up the request side
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 80;
  localparam int REPORT_MAX  = 10;
  localparam int RANDOM_REQS = 100;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [tts_pkg::SLOT_W-1:0] slot_id;
    logic                       ok;
    logic                       last;
  } reply_t;

  logic clk = 1'b0;
  logic rst;

  tts_cmd_if cmd_if ();
  tts_res_if res_if ();

  tick_task_scheduler_top #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  // table model
  logic                       task_live    [NUM_SLOTS];
  logic [tts_pkg::TIME_W-1:0] ticks_left   [NUM_SLOTS];
  logic [tts_pkg::TIME_W-1:0] reload_ticks [NUM_SLOTS];
  logic [tts_pkg::RUNS_W-1:0] runs_due     [NUM_SLOTS];
  reply_t                     replies_due  [$];

  int failures      = 0;
  int reported      = 0;
  int replies_seen  = 0;
  int capped_runs   = 0;
  int cycle_count   = 0;
  int hold_reqs     = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int gap_left      = 0;
  int kind_count [4];
  bit send_idle     = 1'b1;
  bit recv_idle     = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               replies_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    failures++;
    if (reported < REPORT_MAX) begin
      $display("error: %s", msg);
      reported++;
    end
  endtask

  task automatic clear_entry(input int s);
    task_live[s]    = 1'b0;
    ticks_left[s]   = '0;
    reload_ticks[s] = '0;
    runs_due[s]     = '0;
  endtask

  // apply one accepted request to the table and queue the replies it causes
  task automatic update_table(input tts_pkg::kind_t k,
                              input logic [tts_pkg::SLOT_W-1:0] sl,
                              input logic [tts_pkg::TIME_W-1:0] sd,
                              input logic [tts_pkg::TIME_W-1:0] per);
    reply_t batch [$];
    bit     placed;
    placed = 1'b0;
    case (k)
      tts_pkg::KIND_REG: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!placed && !task_live[s]) begin
            task_live[s]    = 1'b1;
            ticks_left[s]   = sd;
            reload_ticks[s] = per;
            runs_due[s]     = '0;
            batch.push_back('{4'(s), 1'b1, 1'b1});
            placed = 1'b1;
          end
        end
        if (!placed) batch.push_back('{'0, 1'b0, 1'b1});
      end
      tts_pkg::KIND_DEL: begin
        if (task_live[sl]) begin
          clear_entry(sl);
          batch.push_back('{sl, 1'b1, 1'b1});
        end else begin
          batch.push_back('{sl, 1'b0, 1'b1});
        end
      end
      tts_pkg::KIND_TICK: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (task_live[s]) begin
            if (ticks_left[s] != 0) ticks_left[s] = ticks_left[s] - 1'b1;
            if (ticks_left[s] == 0) begin
              if (runs_due[s] != tts_pkg::RUNS_MAX) runs_due[s] = runs_due[s] + 1'b1;
              else capped_runs++;
              if (reload_ticks[s] != 0) ticks_left[s] = reload_ticks[s];
            end
          end
        end
      end
      default: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (task_live[s] && runs_due[s] != 0) begin
            batch.push_back('{4'(s), 1'b1, 1'b0});
            runs_due[s] = runs_due[s] - 1'b1;
            // one-shot tasks leave the table once they have run
            if (reload_ticks[s] == 0) clear_entry(s);
          end
        end
        if (batch.size() == 0) batch.push_back('{'0, 1'b0, 1'b1});
        else batch[batch.size()-1].last = 1'b1;
      end
    endcase
    foreach (batch[i]) replies_due.push_back(batch[i]);
  endtask

  // returns right after the accepting edge with valid still high
  task automatic send_request(input tts_pkg::kind_t k,
                              input logic [tts_pkg::SLOT_W-1:0] sl,
                              input logic [tts_pkg::TIME_W-1:0] sd,
                              input logic [tts_pkg::TIME_W-1:0] per);
    int gap;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.kind        <= k;
    cmd_if.slot        <= sl;
    cmd_if.start_delay <= sd;
    cmd_if.period      <= per;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    update_table(k, sl, sd, per);
    kind_count[int'(k)]++;
  endtask

  task automatic wait_replies();
    int spin;
    spin = 0;
    cmd_if.valid <= 1'b0;
    while (replies_due.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    // ticks give no reply, so let the engine finish any walk still queued
    repeat (SETTLE) @(posedge clk);
  endtask

  // result side: random gaps after each reply, plus long hold-offs on demand
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      gap_left = 0;
    end else begin
      if (hold_reqs != hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = hold_reqs;
      end
      if (res_if.valid && res_if.ready) gap_left = recv_idle ? $urandom_range(0, 10) : 0;
      else if (gap_left > 0) gap_left--;
      if (hold_left > 0) hold_left--;
      res_if.ready <= (gap_left == 0 && hold_left == 0);
    end
  end

  always @(posedge clk) begin : check_reply
    reply_t got;
    reply_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = '{res_if.slot_id, res_if.ok, res_if.last};
      replies_seen++;
      if (replies_due.size() == 0) begin
        note_failure($sformatf("unexpected reply slot_id=%0d ok=%0b last=%0b",
                               got.slot_id, got.ok, got.last));
      end else begin
        want = replies_due.pop_front();
        if (got !== want)
          note_failure($sformatf({"reply %0d: expected slot_id=%0d ok=%0b last=%0b,",
                                  " got slot_id=%0d ok=%0b last=%0b"},
                                 replies_seen, want.slot_id, want.ok, want.last,
                                 got.slot_id, got.ok, got.last));
      end
    end
  end

  task automatic test_empty_table();
    send_request(tts_pkg::KIND_DISP, 4'hF, 16'hFFFF, 16'hFFFF);
    send_request(tts_pkg::KIND_DEL, 4'h0, 16'h0000, 16'h0000);
    send_request(tts_pkg::KIND_DEL, 4'hF, 16'h0000, 16'h0000);
    send_request(tts_pkg::KIND_TICK, 4'hA, 16'h5555, 16'hAAAA);
    send_request(tts_pkg::KIND_DISP, 4'h5, 16'hAAAA, 16'h5555);
    wait_replies();
  endtask

  task automatic test_fill_table();
    send_request(tts_pkg::KIND_REG, 4'h0, 16'd0, 16'd0);        // one-shot due at the first tick
    send_request(tts_pkg::KIND_REG, 4'h0, 16'd1, 16'd0);
    send_request(tts_pkg::KIND_REG, 4'h0, 16'd2, 16'd3);
    send_request(tts_pkg::KIND_REG, 4'hF, 16'hFFFF, 16'hFFFF);
    send_request(tts_pkg::KIND_REG, 4'h0, 16'd0, 16'd1);
    for (int i = 5; i < NUM_SLOTS; i++)
      send_request(tts_pkg::KIND_REG, 4'($urandom), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 2)));
    send_request(tts_pkg::KIND_REG, 4'h0, 16'd1, 16'd1);        // table full
    send_request(tts_pkg::KIND_DEL, 4'h3, 16'd0, 16'd0);
    send_request(tts_pkg::KIND_REG, 4'h0, 16'hAAAA, 16'h5555);  // reuses the freed slot
    send_request(tts_pkg::KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_DISP, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_DISP, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_DISP, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_DEL, 4'h3, 16'd0, 16'd0);
    send_request(tts_pkg::KIND_DEL, 4'h3, 16'd0, 16'd0);
    wait_replies();
  endtask

  task automatic test_saturation();
    for (int s = 0; s < NUM_SLOTS; s++)
      send_request(tts_pkg::KIND_DEL, 4'(s), 16'd0, 16'd0);
    send_request(tts_pkg::KIND_REG, 4'h0, 16'd1, 16'd1);
    send_request(tts_pkg::KIND_REG, 4'h0, 16'd0, 16'd0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (300)
      send_request(tts_pkg::KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    repeat (3)
      send_request(tts_pkg::KIND_DISP, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    send_request(tts_pkg::KIND_DISP, 4'($urandom), 16'($urandom), 16'($urandom));
    send_idle = 1'b1;
    recv_idle = 1'b1;
    wait_replies();
  endtask

  task automatic test_random_stream();
    int                         live [$];
    int                         pick;
    logic [tts_pkg::SLOT_W-1:0] sl;
    logic [tts_pkg::TIME_W-1:0] sd;
    logic [tts_pkg::TIME_W-1:0] per;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      // a stretch in the middle runs at full rate on both sides
      send_idle = (i < 40 || i >= 70);
      recv_idle = send_idle;
      pick = $urandom_range(0, 99);
      sl   = 4'($urandom);
      sd   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      per  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      if (pick < 25) begin
        send_request(tts_pkg::KIND_REG, sl, sd, per);
      end else if (pick < 42) begin
        live.delete();
        for (int s = 0; s < NUM_SLOTS; s++) if (task_live[s]) live.push_back(s);
        if (live.size() != 0 && $urandom_range(0, 3) != 0)
          sl = 4'(live[$urandom_range(0, live.size() - 1)]);
        send_request(tts_pkg::KIND_DEL, sl, sd, per);
      end else if (pick < 72) begin
        send_request(tts_pkg::KIND_TICK, sl, sd, per);
      end else begin
        send_request(tts_pkg::KIND_DISP, sl, sd, per);
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
    wait_replies();
  endtask

  task automatic test_backpressure();
    int pick;
    send_idle = 1'b0;
    hold_reqs++;
    for (int i = 0; i < 20; i++) begin
      pick = $urandom_range(0, 3);
      if (pick == 0)
        send_request(tts_pkg::KIND_REG, 4'($urandom), 16'($urandom_range(0, 1)),
                     16'($urandom_range(1, 2)));
      else if (pick == 1)
        send_request(tts_pkg::KIND_DEL, 4'($urandom), 16'($urandom), 16'($urandom));
      else if (pick == 2)
        send_request(tts_pkg::KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
      else
        send_request(tts_pkg::KIND_DISP, 4'($urandom), 16'($urandom), 16'($urandom));
    end
    send_idle = 1'b1;
    wait_replies();
  endtask

  initial begin
    rst                <= 1'b1;
    cmd_if.valid       <= 1'b0;
    cmd_if.kind        <= tts_pkg::KIND_REG;
    cmd_if.slot        <= '0;
    cmd_if.start_delay <= '0;
    cmd_if.period      <= '0;
    foreach (kind_count[i]) kind_count[i] = 0;
    for (int s = 0; s < NUM_SLOTS; s++) clear_entry(s);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_fill_table();
    test_saturation();
    test_random_stream();
    test_backpressure();

    if (replies_due.size() != 0)
      note_failure($sformatf("%0d expected replies never arrived", replies_due.size()));
    $display("sent %0d registers, %0d deletes, %0d ticks, %0d dispatches",
             kind_count[int'(tts_pkg::KIND_REG)], kind_count[int'(tts_pkg::KIND_DEL)],
             kind_count[int'(tts_pkg::KIND_TICK)], kind_count[int'(tts_pkg::KIND_DISP)]);
    $display("%0d replies checked, %0d runs held at the count limit, %0d errors",
             replies_seen, capped_runs, failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tts_pkg.sv
sv/tts_cmd_if.sv
sv/tts_res_if.sv
sv/tts_front.sv
sv/tts_back.sv
sv/tick_task_scheduler_top.sv
sim/tb.sv
